// ===== design/ibq_pkg.sv =====
package ibq_pkg;

  localparam int CW    = 24;
  localparam int FB    = 16;
  localparam int GUARD = FB + 2;
  localparam int OW    = 20;
  localparam int TW    = 8;
  localparam int AB    = 3;

  localparam int DFW   = CW + 1;
  localparam int PRW   = 2 * DFW;
  localparam int AW    = PRW + 1;
  localparam int LOB   = AW / 2;
  localparam int HW    = AW - LOB;
  localparam int PPW   = 2 * HW;
  localparam int CRW   = AW + 2;
  localparam int CCW   = CRW + GUARD;
  localparam int DW    = 2 * AW + 2;
  localparam int SQW   = ((DW - 1 + 2 * GUARD + 1) / 2) * 2;
  localparam int RTW   = SQW / 2;
  localparam int REMW  = RTW + 3;
  localparam int EW    = CCW + 2;
  localparam int NSH   = 2 + GUARD + FB;
  localparam int QB    = OW + 1;
  localparam int RW    = EW + 1 + QB;
  localparam int FST   = 6;
  localparam int PST   = 4;
  localparam int DIV_LAT = QB + 4;
  localparam int PW2   = 2 * (OW + 1);
  localparam int WW    = PW2 - FB + 1;

  localparam logic signed [OW-1:0] ONE  = OW'(1 << FB);
  localparam logic signed [OW-1:0] OMAX = OW'((1 << (OW - 1)) - 1);
  localparam logic signed [OW-1:0] OMIN = OW'(1 << (OW - 1));

  localparam logic REG_CTOL = 1'b0;
  localparam logic REG_WTOL = 1'b1;

  typedef struct packed {
    logic vld;
    logic bad;
    logic signed [AW-1:0] a0;
    logic signed [AW-1:0] a3;
    logic signed [CCW-1:0] c0;
    logic signed [CCW-1:0] c3;
  } pay_t;

  typedef struct packed {
    logic vld;
    logic bad;
  } side_t;

  function automatic logic signed [OW-1:0] snap_coord(input logic signed [OW-1:0] x,
                                                      input logic [TW-1:0] tol);
    logic signed [OW:0] xe;
    logic signed [OW:0] de;
    logic [OW:0] ax;
    logic [OW:0] ad;
    logic signed [OW-1:0] r;
    r = x;
    xe = (OW + 1)'(x);
    ax = xe[OW] ? -xe : xe;
    if (ax < (OW + 1)'(tol)) r = '0;
    de = (OW + 1)'(r) - (OW + 1)'(ONE);
    ad = de[OW] ? -de : de;
    if (ad < (OW + 1)'(tol)) r = ONE;
    return r;
  endfunction

  function automatic logic in_unit(input logic signed [OW-1:0] u,
                                   input logic signed [OW-1:0] v);
    return !u[OW-1] && !v[OW-1] && (u <= ONE) && (v <= ONE);
  endfunction

  function automatic logic signed [OW-1:0] snap_weight(input logic signed [WW-1:0] w,
                                                       input logic [TW-1:0] tol);
    logic signed [WW-1:0] de;
    logic [WW-1:0] aw;
    logic [WW-1:0] ad;
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    logic signed [OW-1:0] r;
    hi = WW'(OMAX);
    lo = WW'(OMIN);
    de = w - WW'(ONE);
    aw = w[WW-1] ? -w : w;
    ad = de[WW-1] ? -de : de;
    if (aw <= WW'(tol)) r = '0;
    else if (ad <= WW'(tol)) r = ONE;
    else if (w > hi) r = OMAX;
    else if (w < lo) r = OMIN;
    else r = w[OW-1:0];
    return r;
  endfunction

endpackage

// ===== design/ibq_front.sv =====
module ibq_front import ibq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic signed [CW-1:0] qx,
  input  logic signed [CW-1:0] qy,
  input  logic signed [CW-1:0] px [4],
  input  logic signed [CW-1:0] py [4],
  output pay_t                 pay,
  output logic signed [DW-1:0] d
);

  // area k = cross(p[PA], p[PB]) about the query point: a0..a3, b0, b1
  localparam int PA [6] = '{0, 1, 2, 3, 3, 0};
  localparam int PB [6] = '{1, 2, 3, 0, 1, 2};
  // discriminant products: b0*b0, b1*b1, a0*a2, a1*a3
  localparam int MX [4] = '{4, 5, 0, 1};
  localparam int MY [4] = '{4, 5, 2, 3};

  logic [FST-1:0] vld;
  logic signed [DFW-1:0] dx [4];
  logic signed [DFW-1:0] dy [4];
  logic signed [PRW-1:0] t1 [6];
  logic signed [PRW-1:0] t2 [6];
  logic signed [AW-1:0] ar [6];
  logic signed [HW-1:0] xh [4];
  logic signed [HW-1:0] xl [4];
  logic signed [HW-1:0] yh [4];
  logic signed [HW-1:0] yl [4];
  logic signed [PPW-1:0] pp [4][4];
  logic signed [DW-1:0] pr5 [4];
  logic signed [CRW-1:0] c0r4, c3r4, c0r5, c3r5;
  logic signed [AW-1:0] a0r4, a3r4, a0r5, a3r5, a0r6, a3r6;
  logic signed [CCW-1:0] c06, c36;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FST-2:0], vld_in};
    end
  end

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      xh[m] = ar[MX[m]][AW-1:LOB];
      xl[m] = HW'({1'b0, ar[MX[m]][LOB-1:0]});
      yh[m] = ar[MY[m]][AW-1:LOB];
      yl[m] = HW'({1'b0, ar[MY[m]][LOB-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        dx[i] <= {px[i][CW-1], px[i]} - {qx[CW-1], qx};
        dy[i] <= {py[i][CW-1], py[i]} - {qy[CW-1], qy};
      end
      for (int k = 0; k < 6; k++) begin
        t1[k] <= dx[PA[k]] * dy[PB[k]];
        t2[k] <= dy[PA[k]] * dx[PB[k]];
        ar[k] <= t1[k] - t2[k];
      end
      for (int m = 0; m < 4; m++) begin
        pp[m][0] <= xh[m] * yh[m];
        pp[m][1] <= xh[m] * yl[m];
        pp[m][2] <= xl[m] * yh[m];
        pp[m][3] <= xl[m] * yl[m];
        pr5[m] <= (DW'(pp[m][0]) <<< (2 * LOB))
                + ((DW'(pp[m][1]) + DW'(pp[m][2])) <<< LOB)
                + DW'(pp[m][3]);
      end
      c0r4 <= (CRW'(ar[0]) <<< 1) - CRW'(ar[4]) - CRW'(ar[5]);
      c3r4 <= (CRW'(ar[3]) <<< 1) + CRW'(ar[5]) - CRW'(ar[4]);
      a0r4 <= ar[0];
      a3r4 <= ar[3];
      c0r5 <= c0r4;
      c3r5 <= c3r4;
      a0r5 <= a0r4;
      a3r5 <= a3r4;
      d    <= pr5[0] + pr5[1] + (pr5[2] <<< 1) + (pr5[3] <<< 1);
      c06  <= CCW'(c0r5) <<< GUARD;
      c36  <= CCW'(c3r5) <<< GUARD;
      a0r6 <= a0r5;
      a3r6 <= a3r5;
    end
  end

  always_comb begin
    pay.vld = vld[FST-1];
    pay.bad = d[DW-1];
    pay.a0  = a0r6;
    pay.a3  = a3r6;
    pay.c0  = c06;
    pay.c3  = c36;
  end

endmodule

// ===== design/ibq_sqrt.sv =====
module ibq_sqrt import ibq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  pay_t                 pay_in,
  input  logic signed [DW-1:0] d,
  output pay_t                 pay_out,
  output logic [RTW-1:0]       s
);

  // one root bit per stage, radicand is d scaled by 4^GUARD
  pay_t pst [RTW];
  logic [DW-2:0] xst [RTW];
  logic [REMW-1:0] rm [RTW];
  logic [RTW-1:0] rt [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_st
    localparam int P0 = 2 * (RTW - 1 - k) - 2 * GUARD;
    localparam int P1 = P0 + 1;
    pay_t pi;
    logic [DW-2:0] xi;
    logic [REMW-1:0] ri;
    logic [RTW-1:0] qi;
    logic [1:0] pr;
    logic [REMW-1:0] rsh;
    logic [REMW-1:0] tt;
    logic ge;

    if (k == 0) begin : g_first
      assign pi = pay_in;
      assign xi = d[DW-2:0];
      assign ri = '0;
      assign qi = '0;
    end else begin : g_next
      assign pi = pst[k-1];
      assign xi = xst[k-1];
      assign ri = rm[k-1];
      assign qi = rt[k-1];
    end

    if (P0 >= 0 && P0 < DW - 1) begin : g_b0
      assign pr[0] = xi[P0];
    end else begin : g_z0
      assign pr[0] = 1'b0;
    end
    if (P1 >= 0 && P1 < DW - 1) begin : g_b1
      assign pr[1] = xi[P1];
    end else begin : g_z1
      assign pr[1] = 1'b0;
    end

    assign rsh = {ri[REMW-3:0], pr};
    assign tt  = REMW'({qi, 2'b01});
    assign ge  = rsh >= tt;

    always_ff @(posedge clk) begin
      if (rst) begin
        pst[k].vld <= 1'b0;
      end else if (en) begin
        pst[k] <= pi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xst[k] <= xi;
        rm[k]  <= ge ? rsh - tt : rsh;
        rt[k]  <= {qi[RTW-2:0], ge};
      end
    end
  end

  assign pay_out = pst[RTW-1];
  assign s       = rt[RTW-1];

endmodule

// ===== design/ibq_div.sv =====
module ibq_div import ibq_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  alt,
  input  logic signed [AW-1:0]  a,
  input  logic signed [CCW-1:0] c,
  input  logic [RTW-1:0]        s,
  output logic signed [OW-1:0]  q
);

  // round(2a*2^(GUARD+FB) / (c +- s)), ties away from zero, one quotient bit a stage
  logic signed [EW-1:0] ce, se;
  logic signed [EW-1:0] e0;
  logic signed [AW-1:0] a0;
  logic [EW-1:0] em;
  logic [AW-1:0] am;
  logic [RW-1:0] num1, num2;
  logic [EW:0] den1, den2;
  logic neg1, neg2, zero1, zero2, ovf2;
  logic [RW-1:0] rr [QB];
  logic [QB-1:0] qq [QB];
  logic [EW:0] dd [QB];
  logic ng [QB];
  logic zr [QB];
  logic ov [QB];

  assign ce = EW'(c);
  assign se = $signed(EW'(s));
  assign em = e0[EW-1] ? -e0 : e0;
  assign am = a0[AW-1] ? -a0 : a0;

  always_ff @(posedge clk) begin
    if (en) begin
      e0    <= alt ? ce - se : ce + se;
      a0    <= a;
      num1  <= (RW'(am) << NSH) + RW'(em);
      den1  <= {em, 1'b0};
      neg1  <= a0[AW-1] ^ e0[EW-1];
      zero1 <= a0 == '0;
      num2  <= num1;
      den2  <= den1;
      neg2  <= neg1;
      zero2 <= zero1;
      ovf2  <= num1 >= (RW'(den1) << QB);
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int B = QB - 1 - j;
    logic [RW-1:0] ri;
    logic [QB-1:0] qi;
    logic [EW:0] di;
    logic ni, zi, oi;
    logic [RW-1:0] ds;
    logic ge;

    if (j == 0) begin : g_first
      assign ri = num2;
      assign qi = '0;
      assign di = den2;
      assign ni = neg2;
      assign zi = zero2;
      assign oi = ovf2;
    end else begin : g_next
      assign ri = rr[j-1];
      assign qi = qq[j-1];
      assign di = dd[j-1];
      assign ni = ng[j-1];
      assign zi = zr[j-1];
      assign oi = ov[j-1];
    end

    assign ds = RW'(di) << B;
    assign ge = ri >= ds;

    always_ff @(posedge clk) begin
      if (en) begin
        rr[j] <= ge ? ri - ds : ri;
        qq[j] <= {qi[QB-2:0], ge};
        dd[j] <= di;
        ng[j] <= ni;
        zr[j] <= zi;
        ov[j] <= oi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zr[QB-1]) begin
        q <= '0;
      end else if (ov[QB-1]) begin
        q <= ng[QB-1] ? OMIN : OMAX;
      end else if (ng[QB-1]) begin
        q <= (qq[QB-1] > QB'(1 << (OW - 1))) ? OMIN : -OW'(qq[QB-1]);
      end else begin
        q <= (qq[QB-1] > QB'((1 << (OW - 1)) - 1)) ? OMAX : OW'(qq[QB-1]);
      end
    end
  end

endmodule

// ===== design/ibq_post.sv =====
module ibq_post import ibq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  side_t                side,
  input  logic signed [OW-1:0] v,
  input  logic signed [OW-1:0] u,
  input  logic signed [OW-1:0] va,
  input  logic signed [OW-1:0] ua,
  input  logic [TW-1:0]        ctol,
  input  logic [TW-1:0]        wtol,
  output logic                 vld,
  output logic                 ok,
  output logic signed [OW-1:0] ou,
  output logic signed [OW-1:0] ov,
  output logic signed [OW-1:0] w00,
  output logic signed [OW-1:0] w10,
  output logic signed [OW-1:0] w11,
  output logic signed [OW-1:0] w01
);

  logic [PST-1:0] vl;
  logic [PST-2:0] bd;
  logic signed [OW-1:0] su, sv, sua, sva;
  logic sel;
  logic signed [OW-1:0] u1, v1, u2, v2, u3, v3;
  logic signed [OW:0] ue, ve, nu, nv;
  logic signed [PW2-1:0] p [4];
  logic signed [WW-1:0] w3 [4];
  logic [PW2-1:0] pa [4];
  logic [PW2-1:0] pm [4];

  always_comb begin
    su  = snap_coord(u, ctol);
    sv  = snap_coord(v, ctol);
    sua = snap_coord(ua, ctol);
    sva = snap_coord(va, ctol);
    sel = !in_unit(su, sv) && in_unit(sua, sva);
    ue  = (OW + 1)'(u1);
    ve  = (OW + 1)'(v1);
    nu  = (OW + 1)'(ONE) - ue;
    nv  = (OW + 1)'(ONE) - ve;
    for (int i = 0; i < 4; i++) begin
      pa[i] = p[i][PW2-1] ? -p[i] : p[i];
      pm[i] = (pa[i] + PW2'(1 << (FB - 1))) >> FB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else if (en) begin
      vl <= {vl[PST-2:0], side.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bd   <= {bd[PST-3:0], side.bad};
      u1   <= sel ? sua : su;
      v1   <= sel ? sva : sv;
      p[0] <= nu * nv;
      p[1] <= ue * nv;
      p[2] <= ue * ve;
      p[3] <= nu * ve;
      u2   <= u1;
      v2   <= v1;
      for (int i = 0; i < 4; i++) begin
        w3[i] <= p[i][PW2-1] ? -$signed(WW'(pm[i])) : $signed(WW'(pm[i]));
      end
      u3   <= u2;
      v3   <= v2;
      ok   <= !bd[PST-2];
      ou   <= bd[PST-2] ? '0 : u3;
      ov   <= bd[PST-2] ? '0 : v3;
      w00  <= bd[PST-2] ? '0 : snap_weight(w3[0], wtol);
      w10  <= bd[PST-2] ? '0 : snap_weight(w3[1], wtol);
      w11  <= bd[PST-2] ? '0 : snap_weight(w3[2], wtol);
      w01  <= bd[PST-2] ? '0 : snap_weight(w3[3], wtol);
    end
  end

  assign vld = vl[PST-1];

endmodule

// ===== design/inverse_bilinear_quad_coords.sv =====
// Inverse bilinear coordinates of a query point in a quad: one request per cycle while not
// stalled, fully pipelined. Stages in order: areas and discriminant, the square root at one
// root bit per stage, the four parallel dividers at one quotient bit per stage, then snapping
// and weights. The whole pipeline holds while a finished result waits on res_stall, so stall
// follows res_valid && res_stall. Snap tolerances sit at APB byte addresses 0 and 4 and are
// read live by the snap stages.
module inverse_bilinear_quad_coords import ibq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 stall,
  input  logic signed [CW-1:0] query_x,
  input  logic signed [CW-1:0] query_y,
  input  logic signed [CW-1:0] corner0_x,
  input  logic signed [CW-1:0] corner0_y,
  input  logic signed [CW-1:0] corner1_x,
  input  logic signed [CW-1:0] corner1_y,
  input  logic signed [CW-1:0] corner2_x,
  input  logic signed [CW-1:0] corner2_y,
  input  logic signed [CW-1:0] corner3_x,
  input  logic signed [CW-1:0] corner3_y,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic                 coords_valid,
  output logic signed [OW-1:0] coord_u,
  output logic signed [OW-1:0] coord_v,
  output logic signed [OW-1:0] weight_00,
  output logic signed [OW-1:0] weight_10,
  output logic signed [OW-1:0] weight_11,
  output logic signed [OW-1:0] weight_01,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AB-1:0]        paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic en;
  logic [TW-1:0] ctol, wtol;
  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];
  pay_t fpay, spay;
  logic signed [DW-1:0] d;
  logic [RTW-1:0] s;
  logic signed [OW-1:0] qv, qu, qva, qua;
  side_t sd [DIV_LAT];

  assign en     = !(res_valid && res_stall);
  assign stall  = !en;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctol <= TW'(1);
      wtol <= TW'(1);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_CTOL: ctol <= pwdata[TW-1:0];
        REG_WTOL: wtol <= pwdata[TW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CTOL: prdata = 32'(ctol);
      REG_WTOL: prdata = 32'(wtol);
    endcase
  end

  assign px[0] = corner0_x;
  assign px[1] = corner1_x;
  assign px[2] = corner2_x;
  assign px[3] = corner3_x;
  assign py[0] = corner0_y;
  assign py[1] = corner1_y;
  assign py[2] = corner2_y;
  assign py[3] = corner3_y;

  ibq_front u_front (
    .clk(clk), .rst(rst), .en(en), .vld_in(valid),
    .qx(query_x), .qy(query_y), .px(px), .py(py),
    .pay(fpay), .d(d)
  );

  ibq_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .pay_in(fpay), .d(d),
    .pay_out(spay), .s(s)
  );

  ibq_div u_div_v (
    .clk(clk), .en(en), .alt(1'b0), .a(spay.a0), .c(spay.c0), .s(s), .q(qv)
  );

  ibq_div u_div_u (
    .clk(clk), .en(en), .alt(1'b0), .a(spay.a3), .c(spay.c3), .s(s), .q(qu)
  );

  ibq_div u_div_va (
    .clk(clk), .en(en), .alt(1'b1), .a(spay.a0), .c(spay.c0), .s(s), .q(qva)
  );

  ibq_div u_div_ua (
    .clk(clk), .en(en), .alt(1'b1), .a(spay.a3), .c(spay.c3), .s(s), .q(qua)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) sd[i].vld <= 1'b0;
    end else if (en) begin
      sd[0].vld <= spay.vld;
      sd[0].bad <= spay.bad;
      for (int i = 1; i < DIV_LAT; i++) sd[i] <= sd[i-1];
    end
  end

  ibq_post u_post (
    .clk(clk), .rst(rst), .en(en), .side(sd[DIV_LAT-1]),
    .v(qv), .u(qu), .va(qva), .ua(qua), .ctol(ctol), .wtol(wtol),
    .vld(res_valid), .ok(coords_valid), .ou(coord_u), .ov(coord_v),
    .w00(weight_00), .w10(weight_10), .w11(weight_11), .w01(weight_01)
  );

`ifndef ASSERT_OFF
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !coords_valid |-> coord_u == '0 && coord_v == '0 && weight_00 == '0
      && weight_10 == '0 && weight_11 == '0 && weight_01 == '0)
    else $error("invalid result carries nonzero fields");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    res_valid && coords_valid && coord_u == '0 && coord_v == '0
      |-> weight_00 == ONE && weight_10 == '0 && weight_11 == '0 && weight_01 == '0)
    else $error("weights wrong at u = v = 0");

  a_far: assert property (@(posedge clk) disable iff (rst)
    res_valid && coords_valid && coord_u == ONE && coord_v == ONE
      |-> weight_11 == ONE && weight_00 == '0 && weight_10 == '0 && weight_01 == '0)
    else $error("weights wrong at u = v = 1");
`endif

endmodule
